### hdl/gb18030_char_counter_core_defines.svh
// Assertion macros used by the port-level checker of the GB18030 character counter.
`ifndef GB18030_CHAR_COUNTER_CORE_DEFINES_SVH
`define GB18030_CHAR_COUNTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define GBCC_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define GBCC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/gbcc_pkg.sv
// Types and byte-range constants for the GB18030 character counter.
package gbcc_pkg;

  // Width of the reported character count.
  localparam int unsigned CharCountW = 16;

  // Byte ranges of the GB18030 layout.
  localparam logic [7:0] AsciiMax    = 8'h7f;
  localparam logic [7:0] LeadMin     = 8'h81;
  localparam logic [7:0] LeadMax     = 8'hfe;
  localparam logic [7:0] Trail2LoMin = 8'h40;
  localparam logic [7:0] Trail2LoMax = 8'h7e;
  localparam logic [7:0] Trail2HiMin = 8'h80;
  localparam logic [7:0] Trail2HiMax = 8'hfe;
  localparam logic [7:0] DigitMin    = 8'h30;
  localparam logic [7:0] DigitMax    = 8'h39;
  localparam logic [7:0] NulByte     = 8'h00;

  // Position inside a multi-byte sequence.
  typedef enum logic [1:0] {
    PhLead   = 2'd0,
    PhSecond = 2'd1,
    PhThird  = 2'd2,
    PhFourth = 2'd3
  } phase_e;

  // Outcome of decoding one byte at a given position.
  typedef struct packed {
    phase_e next_phase;
    logic   count_one;
    logic   error;
    logic   terminate;
  } decode_t;

endpackage

### hdl/gb18030_char_counter_core.sv
// GB18030 character counter: top level with string state and result register.
//
//   Channel | Direction | Handshake               | Payload
//   --------+-----------+-------------------------+--------------------------------
//   in      | input     | in_valid_i / in_ready_o | byte_value_i, last_byte_i
//   out     | output    | out_valid_o/out_ready_i | char_count_o, encoding_error_o
//
// One byte is taken per clock; the string state updates in the cycle of the
// transaction and the result of a last byte appears in the result register
// in the next cycle. A byte that is not last is taken even while a result waits.
// A last byte waits only while the result register is full and not being taken.
// Reset (rst_ni low, asynchronous) clears the string state and the result valid.
module gb18030_char_counter_core
  import gbcc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            byte_value_i,
  input  logic                  last_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [CharCountW-1:0] char_count_o,
  output logic                  encoding_error_o
);

  localparam int unsigned ExtW = (COUNT_WIDTH > CharCountW) ? COUNT_WIDTH : CharCountW;

  phase_e                 phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic                   err_q, err_d;
  logic                   term_q, term_d;
  logic                   out_valid_q, out_valid_d;
  logic [CharCountW-1:0]  res_count_q, res_count_d;
  logic                   res_err_q, res_err_d;

  decode_t                dec;
  logic                   accept;
  logic                   active;
  phase_e                 new_phase;
  logic [COUNT_WIDTH-1:0] new_count;
  logic                   new_err;
  logic                   new_term;
  logic [ExtW-1:0]        count_ext;

  gbcc_decode u_decode (
    .phase_i (phase_q),
    .byte_i  (byte_value_i),
    .dec_o   (dec)
  );

  // Only a last byte needs room in the result register.
  assign in_ready_o = !out_valid_q || out_ready_i || !last_byte_i;
  assign accept     = in_valid_i && in_ready_o;

  // Apply the decoded byte unless the string already ended or failed.
  assign active    = !err_q && !term_q;
  assign new_phase = active ? dec.next_phase : phase_q;
  assign new_err   = err_q || (active && dec.error);
  assign new_term  = term_q || (active && dec.terminate);
  assign new_count = (active && dec.count_one && (count_q != {COUNT_WIDTH{1'b1}})) ?
                     count_q + COUNT_WIDTH'(1) : count_q;
  assign count_ext = ExtW'(new_count);

  // Next string state and result register.
  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    err_d       = err_q;
    term_d      = term_q;
    out_valid_d = out_valid_q && !out_ready_i;
    res_count_d = res_count_q;
    res_err_d   = res_err_q;
    if (accept) begin
      if (last_byte_i) begin
        phase_d     = PhLead;
        count_d     = '0;
        err_d       = 1'b0;
        term_d      = 1'b0;
        out_valid_d = 1'b1;
        res_count_d = count_ext[CharCountW-1:0];
        res_err_d   = new_err || (!new_term && (new_phase != PhLead));
      end else begin
        phase_d = new_phase;
        count_d = new_count;
        err_d   = new_err;
        term_d  = new_term;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhLead;
      count_q     <= '0;
      err_q       <= 1'b0;
      term_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      count_q     <= count_d;
      err_q       <= err_d;
      term_q      <= term_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    res_count_q <= res_count_d;
    res_err_q   <= res_err_d;
  end

  assign out_valid_o      = out_valid_q;
  assign char_count_o     = res_count_q;
  assign encoding_error_o = res_err_q;

endmodule

### hdl/gbcc_decode.sv
// Byte classifier: next sequence position and events for one byte.
module gbcc_decode
  import gbcc_pkg::*;
(
  input  phase_e      phase_i,
  input  logic [7:0]  byte_i,
  output decode_t     dec_o
);

  logic is_lead;
  logic is_digit;
  logic is_trail2;

  // Range checks used by the positions; the lead and digit checks serve two positions each.
  assign is_lead   = (byte_i >= LeadMin) && (byte_i <= LeadMax);
  assign is_digit  = (byte_i >= DigitMin) && (byte_i <= DigitMax);
  assign is_trail2 = ((byte_i >= Trail2LoMin) && (byte_i <= Trail2LoMax)) ||
                     ((byte_i >= Trail2HiMin) && (byte_i <= Trail2HiMax));

  // Decide what this byte does at the current position.
  always_comb begin
    dec_o = '{next_phase: phase_i, count_one: 1'b0, error: 1'b0, terminate: 1'b0};
    case (phase_i)
      PhLead: begin
        if (byte_i == NulByte) begin
          dec_o.terminate = 1'b1;
        end else if (byte_i <= AsciiMax) begin
          dec_o.count_one  = 1'b1;
          dec_o.next_phase = PhLead;
        end else if (is_lead) begin
          dec_o.next_phase = PhSecond;
        end else begin
          dec_o.error = 1'b1;
        end
      end
      PhSecond: begin
        if (is_trail2) begin
          dec_o.count_one  = 1'b1;
          dec_o.next_phase = PhLead;
        end else if (is_digit) begin
          dec_o.next_phase = PhThird;
        end else begin
          dec_o.error = 1'b1;
        end
      end
      PhThird: begin
        if (is_lead) begin
          dec_o.next_phase = PhFourth;
        end else begin
          dec_o.error = 1'b1;
        end
      end
      PhFourth: begin
        if (is_digit) begin
          dec_o.count_one  = 1'b1;
          dec_o.next_phase = PhLead;
        end else begin
          dec_o.error = 1'b1;
        end
      end
      default: begin
        dec_o.error = 1'b1;
      end
    endcase
  end

endmodule

### hdl/gbcc_checker.sv
// Port-level checker for the GB18030 character counter, bound to the top level.
`include "gb18030_char_counter_core_defines.svh"

module gbcc_checker
  import gbcc_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic [7:0]            byte_value_i,
  input logic                  last_byte_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [CharCountW-1:0] char_count_o,
  input logic                  encoding_error_o
);

  // A waiting result stays offered.
  `GBCC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped while stalled")

  // A waiting result keeps its payload.
  `GBCC_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(char_count_o) && $stable(encoding_error_o), "result changed while stalled")

  // A last byte is taken only when the result register has room.
  `GBCC_ASSERT_IMPL(a_last_room, in_valid_i && in_ready_o && last_byte_i, !out_valid_o || out_ready_i, "last byte taken over a waiting result")

  // Every taken last byte gives a result in the next cycle.
  `GBCC_ASSERT_NEXT(a_last_result, in_valid_i && in_ready_o && last_byte_i, out_valid_o, "last byte gave no result")

  // A fresh result comes only from a last-byte transaction.
  `GBCC_ASSERT_IMPL(a_no_invented, out_valid_o && (!$past(out_valid_o) || $past(out_ready_i)), $past(in_valid_i && in_ready_o && last_byte_i), "result without a last byte")

endmodule

bind gb18030_char_counter_core gbcc_checker u_gbcc_checker (.*);

### tb/gb18030_char_counter_core_checker.sv
// Checker for the GB18030 character counter: follows each string and compares results.
`timescale 1ns / 100ps
module gb18030_char_counter_core_checker
  import gbcc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [7:0]            byte_value_i,
  input  logic                  last_byte_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [CharCountW-1:0] char_count_i,
  input  logic                  encoding_error_i,
  output logic [31:0]           fail_count_o,
  output logic [31:0]           pending_o,
  output logic [31:0]           checked_o
);

  // Count and error flag that one finished string should report.
  typedef struct packed {
    logic [CharCountW-1:0] count;
    logic                  error;
  } tally_t;

  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  tally_t                 string_tallies[$];
  phase_e                 seq_phase;
  logic [COUNT_WIDTH-1:0] char_total;
  logic                   bad_seen;
  logic                   nul_seen;
  int unsigned            fails;
  int unsigned            checked;

  initial begin
    fail_count_o = '0;
    pending_o    = '0;
    checked_o    = '0;
  end

  function automatic logic in_span(input logic [7:0] b, input logic [7:0] lo,
                                   input logic [7:0] hi);
    return (b >= lo) && (b <= hi);
  endfunction

  task automatic clear_string();
    seq_phase  = PhLead;
    char_total = '0;
    bad_seen   = 1'b0;
    nul_seen   = 1'b0;
  endtask

  // A character is complete; the count holds once it reaches its maximum.
  task automatic close_char();
    if (char_total != CountMax) char_total++;
    seq_phase = PhLead;
  endtask

  // Advances the string state by one byte and queues a tally on the last byte.
  task automatic decode_byte(input logic [7:0] b, input logic is_last);
    tally_t t;
    if (!bad_seen && !nul_seen) begin
      case (seq_phase)
        PhLead: begin
          if (b == NulByte) nul_seen = 1'b1;
          else if (b <= AsciiMax) close_char();
          else if (in_span(b, LeadMin, LeadMax)) seq_phase = PhSecond;
          else bad_seen = 1'b1;
        end
        PhSecond: begin
          if (in_span(b, Trail2LoMin, Trail2LoMax) || in_span(b, Trail2HiMin, Trail2HiMax))
            close_char();
          else if (in_span(b, DigitMin, DigitMax)) seq_phase = PhThird;
          else bad_seen = 1'b1;
        end
        PhThird: begin
          if (in_span(b, LeadMin, LeadMax)) seq_phase = PhFourth;
          else bad_seen = 1'b1;
        end
        default: begin
          if (in_span(b, DigitMin, DigitMax)) close_char();
          else bad_seen = 1'b1;
        end
      endcase
    end
    if (is_last) begin
      // A sequence left open by the end of the string is an error.
      if (!bad_seen && !nul_seen && seq_phase != PhLead) bad_seen = 1'b1;
      t.count = CharCountW'(char_total);
      t.error = bad_seen;
      string_tallies.push_back(t);
      clear_string();
    end
  endtask

  // Compare each result transaction first, then predict from the input transaction.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    tally_t want;
    if (!rst_ni) begin
      string_tallies.delete();
      clear_string();
      fails   = 0;
      checked = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (string_tallies.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, actual count %0d error %0b",
                   $time, char_count_i, encoding_error_i);
        end else begin
          want = string_tallies.pop_front();
          checked++;
          if (char_count_i !== want.count) begin
            fails++;
            $display("%0t: char_count mismatch, expected %0d, actual %0d",
                     $time, want.count, char_count_i);
          end
          if (encoding_error_i !== want.error) begin
            fails++;
            $display("%0t: encoding_error mismatch, expected %0b, actual %0b",
                     $time, want.error, encoding_error_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) decode_byte(byte_value_i, last_byte_i);
    end
    fail_count_o <= fails;
    pending_o    <= string_tallies.size();
    checked_o    <= checked;
  end

endmodule

### tb/tb.sv
// Testbench top for the GB18030 character counter: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb;
  import gbcc_pkg::*;

  localparam int unsigned CountWidth = 16;
  localparam int unsigned HoldCycles = 400;

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic [7:0]            byte_value     = 8'h00;
  logic                  last_byte      = 1'b0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  logic [CharCountW-1:0] char_count;
  logic                  encoding_error;
  logic [31:0]           fail_count;
  logic [31:0]           pending;
  logic [31:0]           checked;

  logic                  holding        = 1'b0;
  int unsigned           send_idle_pct  = 0;
  int unsigned           recv_stall_pct = 0;
  int unsigned           bytes_sent     = 0;
  int unsigned           strings_sent   = 0;
  logic [7:0]            string_bytes[$];
  event                  hold_go;

  // Opening tests: bit 8 marks the last byte of a string.
  localparam int unsigned NumDirected = 29;
  localparam logic [8:0] Directed[NumDirected] = '{
    9'h141,
    9'h100,
    9'h07f, 9'h081, 9'h040, 9'h0fe, 9'h07e, 9'h081, 9'h080, 9'h0fe, 9'h0fe,
    9'h081, 9'h030, 9'h0fe, 9'h139,
    9'h180,
    9'h0ff, 9'h141,
    9'h081, 9'h17f,
    9'h081, 9'h030, 9'h181,
    9'h041, 9'h000, 9'h0ff, 9'h180,
    9'h081, 9'h100
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gb18030_char_counter_core #(
    .COUNT_WIDTH(CountWidth)
  ) DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .byte_value_i    (byte_value),
    .last_byte_i     (last_byte),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .char_count_o    (char_count),
    .encoding_error_o(encoding_error)
  );

  gb18030_char_counter_core_checker #(
    .COUNT_WIDTH(CountWidth)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .byte_value_i    (byte_value),
    .last_byte_i     (last_byte),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .char_count_i    (char_count),
    .encoding_error_i(encoding_error),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  // Receiver: random stalls, forced off while a hold-off is running.
  initial begin
    forever begin
      @(posedge clk);
      if (holding) out_ready <= 1'b0;
      else out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off, counted here in clock cycles.
  initial begin
    forever begin
      @(hold_go);
      holding <= 1'b1;
      repeat (HoldCycles) @(posedge clk);
      holding <= 1'b0;
    end
  end

  // Offers one byte, with an optional random gap, and waits for its transaction.
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    byte_value <= b;
    last_byte  <= is_last;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_string();
    foreach (string_bytes[i]) send_byte(string_bytes[i], i == string_bytes.size() - 1);
    strings_sent++;
  endtask

  // Pauses the sender until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Appends one well-formed character of a random length.
  task automatic add_char();
    logic [7:0] lead;
    lead = 8'($urandom_range(8'h81, 8'hfe));
    case ($urandom_range(2))
      0: string_bytes.push_back(8'($urandom_range(8'h01, 8'h7f)));
      1: begin
        string_bytes.push_back(lead);
        if ($urandom_range(1)) string_bytes.push_back(8'($urandom_range(8'h40, 8'h7e)));
        else string_bytes.push_back(8'($urandom_range(8'h80, 8'hfe)));
      end
      default: begin
        string_bytes.push_back(lead);
        string_bytes.push_back(8'($urandom_range(8'h30, 8'h39)));
        string_bytes.push_back(8'($urandom_range(8'h81, 8'hfe)));
        string_bytes.push_back(8'($urandom_range(8'h30, 8'h39)));
      end
    endcase
  endtask

  // Mostly valid strings; the rest carry one defect or are plain noise.
  task automatic build_string();
    int unsigned pick;
    int unsigned pos;
    string_bytes.delete();
    pick = $urandom_range(99);
    if (pick >= 95) begin
      repeat ($urandom_range(1, 8)) string_bytes.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(1, 10)) add_char();
      pos = $urandom_range(string_bytes.size() - 1);
      if (pick >= 90) begin
        // Sequence cut off by the end of the string.
        string_bytes.push_back(8'($urandom_range(8'h81, 8'hfe)));
        if ($urandom_range(1)) begin
          string_bytes.push_back(8'($urandom_range(8'h30, 8'h39)));
          if ($urandom_range(1)) string_bytes.push_back(8'($urandom_range(8'h81, 8'hfe)));
        end
      end else if (pick >= 85) begin
        // Zero byte, then junk that must be ignored.
        string_bytes.insert(pos, NulByte);
        repeat ($urandom_range(3)) string_bytes.push_back(8'($urandom_range(255)));
      end else if (pick >= 79) begin
        string_bytes[pos] = 8'($urandom_range(255));
      end else if (pick >= 73) begin
        string_bytes.insert(pos, $urandom_range(1) ? 8'h80 : 8'hff);
      end
    end
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input int unsigned budget);
    int unsigned start;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start          = bytes_sent;
    while (bytes_sent - start < budget) begin
      build_string();
      send_string();
    end
    drain();
  endtask

  // Stimulus and verdict.
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed strings: range edges, bad lead and second bytes, a cut-off sequence, zero termination.
    for (int i = 0; i < NumDirected; i++) begin
      send_byte(Directed[i][7:0], Directed[i][8]);
      if (Directed[i][8]) strings_sent++;
    end
    drain();

    run_phase(0, 0, 450);

    // Receiver holds off while short strings keep arriving, so the input backs up.
    -> hold_go;
    repeat (40) begin
      string_bytes.delete();
      add_char();
      send_string();
    end
    drain();

    run_phase(73, 0, 450);
    run_phase(0, 73, 450);
    run_phase(16, 16, 450);

    repeat (10) @(posedge clk);
    $display("Sent %0d bytes in %0d strings and checked %0d results,", bytes_sent,
             strings_sent, checked);
    $display("across idle and stall mixes, directed range edges and a long receiver hold-off.");
    if (fail_count == 0 && pending == 0) begin
      $display("gb18030_char_counter_core regression: pass");
    end else begin
      $display("gb18030_char_counter_core regression: fail");
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #1_000_000;
    $display("gb18030_char_counter_core regression: fail");
    $finish;
  end

endmodule
